@@ rtl/core/cdq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_pkg
// shared types and constants of the circular deque: command and status
// codes, request and response beats, control result between modules
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int OCC_W     = 5;

  typedef enum logic [1:0] {
    CMD_PUSH_REAR  = 2'd0,
    CMD_PUSH_FRONT = 2'd1,
    CMD_POP_REAR   = 2'd2,
    CMD_POP_FRONT  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic signed [DATA_W-1:0] push_data;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pop_data;
    status_t                  status;
    logic [OCC_W-1:0]         occupancy;
  } rsp_t;

  // outcome of one command as seen by the pipeline
  typedef struct packed {
    logic             rd;
    status_t          status;
    logic [OCC_W-1:0] occupancy;
  } ctrl_res_t;

endpackage
`default_nettype wire

@@ rtl/core/cdq_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_ram
// generic single-port ram, one write or one registered read per cycle
// ----------------------------------------------------------------------------
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/cdq_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_ctrl
// front and rear indices and fill count; decodes one command per beat
// into a ram access and a status
// ----------------------------------------------------------------------------
module cdq_ctrl
  import cdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     acc,
  input  wire cmd_t                     cmd,
  output logic                          mem_we,
  output logic                          mem_re,
  output logic      [$clog2(DEPTH)-1:0] mem_addr,
  output ctrl_res_t                     res
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  logic [IW-1:0] head, head_next;
  logic [IW-1:0] tail, tail_next;
  logic [CW-1:0] count, count_next;

  function automatic logic [IW-1:0] wrap_up(input logic [IW-1:0] i);
    return (i == LAST) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IW-1:0] wrap_down(input logic [IW-1:0] i);
    return (i == '0) ? LAST : i - 1'b1;
  endfunction

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = head;
    res.rd     = 1'b0;
    res.status = ST_DONE;
    if (acc) begin
      unique case (cmd) inside
        CMD_PUSH_REAR, CMD_PUSH_FRONT: begin
          if (count == FULL) begin
            res.status = ST_OVERFLOW;
          end else begin
            mem_we = 1'b1;
            if (count == '0) begin
              // first word always lands at entry zero
              head_next = '0;
              tail_next = '0;
              mem_addr  = '0;
            end else if (cmd == CMD_PUSH_REAR) begin
              tail_next = wrap_up(tail);
              mem_addr  = tail_next;
            end else begin
              head_next = wrap_down(head);
              mem_addr  = head_next;
            end
            count_next = count + 1'b1;
          end
        end
        CMD_POP_REAR, CMD_POP_FRONT: begin
          if (count == '0) begin
            res.status = ST_UNDERFLOW;
          end else begin
            mem_re   = 1'b1;
            res.rd   = 1'b1;
            mem_addr = (cmd == CMD_POP_REAR) ? tail : head;
            if (count == CW'(1)) begin
              head_next = '0;
              tail_next = '0;
            end else if (cmd == CMD_POP_REAR) begin
              tail_next = wrap_down(tail);
            end else begin
              head_next = wrap_up(head);
            end
            count_next = count - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    res.occupancy = OCC_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= FULL)
    else $error("fill count above depth");
  a_empty_idx: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> head == '0 && tail == '0)
    else $error("indices not parked while empty");
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    acc && mem_re |=> count == $past(count) - 1'b1)
    else $error("pop did not lower fill count");
`endif

endmodule
`default_nettype wire

@@ rtl/core/circular_deque_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// circular_deque_unit
// double-ended queue of DEPTH words kept in a circular single-port ram
// ----------------------------------------------------------------------------
// Each request beat carries one command: push at rear, push at front, pop
// from rear or pop from front, with a word for pushes. Every command gives
// exactly one response beat with the popped word (zero on pushes and on
// underflow), a status (done, overflow on push when full, underflow on pop
// when empty) and the occupancy after the command. A command is taken every
// cycle as long as responses are taken. A taken request goes into stage one
// while the ram port does its registered read; the response register is
// then loaded from stage one and the ram output once it is free or its
// beat is taken. Requests stall only while stage one and the
// response register both hold a beat and the response is stalled. The
// indices and count live in flip-flops and are updated as the command is
// taken, so a pop that follows a push reads the new word from the ram
// without any forwarding. There is no clearing pass after reset: only
// written entries are ever read.
// ----------------------------------------------------------------------------
module circular_deque_unit
  import cdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  // ram access decoded from the current command
  logic                     mem_we;
  logic                     mem_re;
  logic [$clog2(DEPTH)-1:0] mem_addr;
  logic [DATA_W-1:0]        mem_rdata;
  ctrl_res_t                ctrl_res;

  // stage one: command taken, ram read in flight
  logic      s1_valid;
  ctrl_res_t s1;
  logic      s1_move;
  logic      acc;

  // stage two is the response register itself
  logic out_valid;
  rsp_t out_reg;

  assign s1_move   = s1_valid && (!out_valid || !rsp_stall);
  // stall only when both stages are full and the response is held
  assign req_stall = s1_valid && out_valid && rsp_stall;
  assign acc       = req_valid && !req_stall;

  cdq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .acc     (acc),
    .cmd     (req.cmd),
    .mem_we  (mem_we),
    .mem_re  (mem_re),
    .mem_addr(mem_addr),
    .res     (ctrl_res)
  );

  cdq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .re   (mem_re),
    .addr (mem_addr),
    .wdata(DATA_W'(req.push_data)),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= acc || (s1_valid && !s1_move);
      out_valid <= s1_move || (out_valid && rsp_stall);
    end
  end

  // payload, no reset; ram output holds while stage one waits since no
  // read is issued until a new command is taken
  always_ff @(posedge clk) begin
    if (acc) begin
      s1 <= ctrl_res;
    end
    if (s1_move) begin
      out_reg.pop_data  <= s1.rd ? $signed(mem_rdata) : '0;
      out_reg.status    <= s1.status;
      out_reg.occupancy <= s1.occupancy;
    end
  end

  assign rsp_valid = out_valid;
  assign rsp       = out_reg;

`ifndef SYNTHESIS
  a_hold_rdata: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |-> !mem_re)
    else $error("ram read issued while stage one is held");
`endif

endmodule
`default_nettype wire

@@ dv/cdq_monitor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_monitor
// watches both channels of the deque, predicts every response beat from the
// accepted request beats and compares field by field in arrival order
// ----------------------------------------------------------------------------
module cdq_monitor
  import cdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   fail_count,
  output int   pending
);

  localparam int MAX_PRINTS = 40;

  logic [DATA_W-1:0] words [DEPTH];
  int                front_idx;
  int                rear_idx;
  int                fill;
  rsp_t              due_rsp [$];
  int                errs  = 0;
  int                due_n = 0;

  assign fail_count = errs;
  assign pending    = due_n;

  function automatic int step_up(int i);
    return (i >= DEPTH - 1) ? 0 : i + 1;
  endfunction

  function automatic int step_down(int i);
    return (i == 0) ? DEPTH - 1 : i - 1;
  endfunction

  // applies one command to the deque copy and returns the response it owes
  function automatic rsp_t apply_command(req_t r);
    rsp_t o;
    o.pop_data = '0;
    o.status   = ST_DONE;
    if (r.cmd == CMD_PUSH_REAR || r.cmd == CMD_PUSH_FRONT) begin
      if (fill >= DEPTH) begin
        o.status = ST_OVERFLOW;
      end else begin
        if (fill == 0) begin
          front_idx = 0;
          rear_idx  = 0;
          words[0]  = r.push_data;
        end else if (r.cmd == CMD_PUSH_REAR) begin
          rear_idx        = step_up(rear_idx);
          words[rear_idx] = r.push_data;
        end else begin
          front_idx        = step_down(front_idx);
          words[front_idx] = r.push_data;
        end
        fill++;
      end
    end else begin
      if (fill == 0) begin
        o.status = ST_UNDERFLOW;
      end else begin
        o.pop_data = (r.cmd == CMD_POP_REAR) ? words[rear_idx] : words[front_idx];
        if (fill == 1) begin
          front_idx = 0;
          rear_idx  = 0;
        end else if (r.cmd == CMD_POP_REAR) begin
          rear_idx = step_down(rear_idx);
        end else begin
          front_idx = step_up(front_idx);
        end
        fill--;
      end
    end
    o.occupancy = OCC_W'(fill);
    return o;
  endfunction

  task automatic report(string field, logic [DATA_W-1:0] want_v, logic [DATA_W-1:0] got_v);
    errs++;
    if (errs <= MAX_PRINTS)
      $display("%0t mismatch %s: expected %h, actual %h", $realtime, field, want_v, got_v);
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      front_idx = 0;
      rear_idx  = 0;
      fill      = 0;
      due_rsp.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (due_rsp.size() == 0) begin
          errs++;
          if (errs <= MAX_PRINTS)
            $display("%0t unexpected response beat: expected none, actual %h", $realtime, rsp);
        end else begin
          want = due_rsp.pop_front();
          if (rsp.pop_data !== want.pop_data)
            report("pop_data", want.pop_data, rsp.pop_data);
          if (rsp.status !== want.status)
            report("status", DATA_W'(want.status), DATA_W'(rsp.status));
          if (rsp.occupancy !== want.occupancy)
            report("occupancy", DATA_W'(want.occupancy), DATA_W'(rsp.occupancy));
        end
      end
      if (req_valid && !req_stall)
        due_rsp.push_back(apply_command(req));
    end
    due_n = due_rsp.size();
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the circular deque: directed corner commands,
// then random command mixes in phases that drive the deque empty and full,
// with bursty requests and a receiver that stalls on its own pattern
// ----------------------------------------------------------------------------
module tb_top
  import cdq_pkg::*;
();

  localparam int DEPTH       = 16;
  localparam int ITEMS       = 1300;
  localparam int LIMIT       = 200000;  // cycles, far above the slowest run
  localparam int HOLD_CYCLES = 400;     // long receiver hold-off
  localparam int HOLD_AFTER  = 500;     // cycles of traffic before the hold-off
  localparam int DRAIN       = 8;       // pipeline latency plus margin

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  req_t req       = '0;
  logic rsp_stall = 1'b0;
  logic req_stall;
  logic rsp_valid;
  rsp_t rsp;
  int   fail_count;
  int   pending;
  int   cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  circular_deque_unit #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  cdq_monitor #(.DEPTH(DEPTH)) monitor (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // offer one request beat and hold it until the deque takes it; the caller
  // either offers the next beat or idles in the same step, never both
  task automatic send_beat(input cmd_t c, input logic [DATA_W-1:0] d);
    req       <= '{cmd: c, push_data: d};
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      req_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // push share in percent decides whether the deque drifts full or empty
  function automatic cmd_t pick_cmd(input int push_pct);
    if ($urandom_range(99) < push_pct)
      return $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
    return $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_REAR;
  endfunction

  // random words half the time, else the sign extremes, zero or all ones
  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // request side: reset, directed corners, then random phases
  initial begin : req_side
    int sent;
    int phase_len;
    int push_pct;
    int burst_left;
    bit gappy;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // underflow from both ends of an empty deque
    send_beat(CMD_POP_REAR,   32'h0000_0000);
    send_beat(CMD_POP_FRONT,  32'hffff_ffff);
    // sign extremes pushed at both ends, the front one wrapping below entry 0
    send_beat(CMD_PUSH_REAR,  32'h7fff_ffff);
    send_beat(CMD_PUSH_FRONT, 32'h8000_0000);
    send_beat(CMD_PUSH_REAR,  32'hffff_ffff);
    send_beat(CMD_PUSH_FRONT, 32'h0000_0000);
    idle_gap(3);
    send_beat(CMD_POP_REAR,   32'h1234_5678);
    send_beat(CMD_POP_FRONT,  32'h0000_0000);
    send_beat(CMD_POP_REAR,   32'h0000_0000);
    // last pop empties the deque and sends both indices home
    send_beat(CMD_POP_FRONT,  32'h0000_0000);
    send_beat(CMD_POP_FRONT,  32'h0000_0000);
    // a front push into an empty deque still lands at entry 0
    send_beat(CMD_PUSH_FRONT, 32'h0000_0001);
    send_beat(CMD_PUSH_FRONT, 32'ha5a5_a5a5);
    send_beat(CMD_POP_FRONT,  32'h0000_0000);
    send_beat(CMD_POP_REAR,   32'h0000_0000);

    // random phases; all-push and all-pop phases pin the deque at full
    // and empty so overflow and underflow come up over and over
    sent       = 0;
    burst_left = 0;
    while (sent < ITEMS) begin
      phase_len = $urandom_range(20, 120);
      case ($urandom_range(6))
        0:       push_pct = 100;
        1:       push_pct = 0;
        2:       push_pct = 85;
        3:       push_pct = 15;
        default: push_pct = 50;
      endcase
      gappy = ($urandom_range(3) != 0);
      repeat (phase_len) begin
        if (gappy && burst_left == 0) begin
          idle_gap($urandom_range(1, 6));
          burst_left = $urandom_range(1, 16);
        end
        send_beat(pick_cmd(push_pct), pick_word());
        if (burst_left > 0) burst_left--;
        sent++;
      end
    end
    req_valid <= 1'b0;

    // drain: every owed beat back, then the DRAIN margin for strays
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // response side: stall pattern of its own, changing per segment, with one
  // long hold-off so the deque pipeline backs up into the request channel
  initial begin : rsp_side
    int  seg_len;
    int  mode;
    int  elapsed;
    bit  held;
    elapsed = 0;
    held    = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (!held && elapsed >= HOLD_AFTER) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        elapsed += HOLD_CYCLES;
        held     = 1'b1;
      end else begin
        seg_len = $urandom_range(10, 150);
        mode    = $urandom_range(3);
        for (int k = 0; k < seg_len; k++) begin
          case (mode)
            0:       rsp_stall <= 1'b0;                       // no back-pressure
            1:       rsp_stall <= ($urandom_range(99) < 25);
            2:       rsp_stall <= ($urandom_range(99) < 60);
            default: rsp_stall <= k[0];                       // every other beat
          endcase
          @(posedge clk);
          elapsed++;
        end
      end
    end
  end

endmodule
